[hw/rtl/crv_pkg.sv]
// Shared types, constants and the CRC-32 byte update for the record validator.
`default_nettype none

package crv_pkg;

   localparam int unsigned HDR_LEN     = 40;
   localparam logic [31:0] CRC_POLY    = 32'hedb8_8320;
   localparam logic [31:0] CRC_INIT    = 32'hffff_ffff;
   // "P9PS" as it lies in memory, byte 0 in the low lane
   localparam logic [31:0] MAGIC_WORD  = 32'h5350_3950;
   localparam logic [7:0]  FLAG_MASK   = 8'h1f;
   localparam logic [7:0]  REC_VERSION = 8'h01;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_PAYLOAD,
      PH_DISCARD
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_BAD_MAGIC,
      ST_BAD_VERSION,
      ST_RESERVED_FLAGS,
      ST_EMPTY_BODY,
      ST_LENGTH_MISMATCH,
      ST_TRUNCATED,
      ST_CRC_MISMATCH
   } status_type;

   // reflected CRC-32, one byte, eight shift steps
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/crv_channels.sv]
// Valid/ready channel interfaces for the record validator's byte input and result output.
`default_nettype none

interface crv_req_if;
   import crv_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       record_start;
   logic       end_of_store;

   modport source (output valid, output data_byte, output record_start,
                   output end_of_store, input ready);
   modport sink   (input valid, input data_byte, input record_start,
                   input end_of_store, output ready);
endinterface

interface crv_rsp_if;
   import crv_pkg::*;
   logic               valid;
   logic               ready;
   status_type         status;
   logic [4:0]         record_flags;
   logic [31:0]        total_bytes;
   logic [31:0]        body_size;
   logic [31:0]        attribute_bytes;
   logic [31:0]        plain_body_size;
   logic signed [31:0] proof_weight;
   logic [63:0]        match_count;

   modport source (output valid, output status, output record_flags, output total_bytes,
                   output body_size, output attribute_bytes, output plain_body_size,
                   output proof_weight, output match_count, input ready);
   modport sink   (input valid, input status, input record_flags, input total_bytes,
                   input body_size, input attribute_bytes, input plain_body_size,
                   input proof_weight, input match_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/crc_checked_record_validator_unit.sv]
// Top level of the CRC-checked record validator: header decode, checks, payload CRC.
// Usage:
//  - req carries one word a cycle: a stream byte with record_start (first byte of a
//    record) and end_of_store (last byte of the store). A word is taken when
//    req.valid and req.ready are both high.
//  - rsp carries at most one result word per input word: status plus the decoded
//    header fields of the record that the input word closed.
//  - Throughput: one input word every cycle while req.ready is high. The header
//    decode, the length check (one 33-bit add and compare) and the eight-step CRC
//    byte update all sit between the state registers and the result register.
//  - Output: a result appears on rsp in the cycle after the word that finished it.
//  - Stall: a held result sits in the result register; req.ready stays high while that
//    register is empty or being taken, so a stalled receiver holds the input back
//    whenever a result is waiting in that register.
//  - Reset (synchronous, active high): no result pending, walker idle, all record
//    fields cleared and the running CRC preset to all ones.
//  - After a header fault bytes are dropped until the next record_start.
`default_nettype none

module crc_checked_record_validator_unit (
   input  wire logic clock,
   input  wire logic reset,
   crv_req_if.sink   req,
   crv_rsp_if.source rsp
);
   import crv_pkg::*;

   // walker state
   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   status_type  fault_ff, fault_in;
   logic [7:0]  flag_lo_ff, flag_lo_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] body_ff, body_in;
   logic [31:0] attr_ff, attr_in;
   logic [31:0] logical_ff, logical_in;
   logic [31:0] weight_ff, weight_in;
   logic [31:0] crc_stored_ff, crc_stored_in;
   logic [63:0] matched_ff, matched_in;
   logic [31:0] crc_run_ff, crc_run_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [4:0]         rsp_flags_ff, rsp_flags_in;
   logic [31:0]        rsp_total_ff, rsp_total_in;
   logic [31:0]        rsp_body_ff, rsp_body_in;
   logic [31:0]        rsp_attr_ff, rsp_attr_in;
   logic [31:0]        rsp_logical_ff, rsp_logical_in;
   logic signed [31:0] rsp_weight_ff, rsp_weight_in;
   logic [63:0]        rsp_matched_ff, rsp_matched_in;

   logic        accept;
   logic        rec_open;
   logic        emit;
   logic        emit_old;   // report the record open before this start byte
   status_type  emit_status;
   status_type  hdr_status;
   logic [5:0]  off;
   logic [1:0]  lane;
   logic [32:0] len_sum;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign rec_open  = (phase_ff == PH_HEADER) || (phase_ff == PH_PAYLOAD);

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      fault_in      = fault_ff;
      flag_lo_in    = flag_lo_ff;
      total_in      = total_ff;
      body_in       = body_ff;
      attr_in       = attr_ff;
      logical_in    = logical_ff;
      weight_in     = weight_ff;
      crc_stored_in = crc_stored_ff;
      matched_in    = matched_ff;
      crc_run_in    = crc_run_ff;
      emit          = 1'b0;
      emit_old      = 1'b0;
      emit_status   = ST_OK;
      hdr_status    = ST_OK;
      off           = count_ff[5:0];
      lane          = off[1:0];
      len_sum       = 33'd0;

      if (accept) begin
         if (req.record_start) begin
            // a start inside an open record cuts that record short
            if (rec_open) begin
               emit        = 1'b1;
               emit_old    = 1'b1;
               emit_status = ST_TRUNCATED;
            end
            phase_in      = PH_HEADER;
            count_in      = 32'd0;
            fault_in      = ST_OK;
            flag_lo_in    = 8'd0;
            total_in      = 32'd0;
            body_in       = 32'd0;
            attr_in       = 32'd0;
            logical_in    = 32'd0;
            weight_in     = 32'd0;
            crc_stored_in = 32'd0;
            matched_in    = 64'd0;
            crc_run_in    = CRC_INIT;
         end

         off  = count_in[5:0];
         lane = off[1:0];

         case (phase_in)
            PH_HEADER: begin
               case (off)
                  6'd0, 6'd1, 6'd2, 6'd3: begin
                     if (req.data_byte != MAGIC_WORD[{lane, 3'b000} +: 8] && fault_in == ST_OK)
                        fault_in = ST_BAD_MAGIC;
                  end
                  6'd4: begin
                     if (req.data_byte != REC_VERSION && fault_in == ST_OK)
                        fault_in = ST_BAD_VERSION;
                  end
                  6'd5: begin
                     if (req.data_byte != 8'd0 && fault_in == ST_OK)
                        fault_in = ST_BAD_VERSION;
                  end
                  6'd6: flag_lo_in = req.data_byte;
                  6'd7: begin
                     if (((flag_lo_in & ~FLAG_MASK) != 8'd0 || req.data_byte != 8'd0)
                         && fault_in == ST_OK)
                        fault_in = ST_RESERVED_FLAGS;
                  end
                  6'd8, 6'd9, 6'd10, 6'd11:   total_in[{lane, 3'b000} +: 8]      = req.data_byte;
                  6'd12, 6'd13, 6'd14, 6'd15: body_in[{lane, 3'b000} +: 8]       = req.data_byte;
                  6'd16, 6'd17, 6'd18, 6'd19: attr_in[{lane, 3'b000} +: 8]       = req.data_byte;
                  6'd20, 6'd21, 6'd22, 6'd23: logical_in[{lane, 3'b000} +: 8]    = req.data_byte;
                  6'd24, 6'd25, 6'd26, 6'd27: weight_in[{lane, 3'b000} +: 8]     = req.data_byte;
                  6'd28, 6'd29, 6'd30, 6'd31: crc_stored_in[{lane, 3'b000} +: 8] = req.data_byte;
                  6'd32, 6'd33, 6'd34, 6'd35,
                  6'd36, 6'd37, 6'd38, 6'd39: matched_in[{off[2:0], 3'b000} +: 8] = req.data_byte;
                  default: ;
               endcase
               count_in = count_in + 32'd1;

               if (count_in == HDR_LEN) begin
                  // header complete: first fault wins, then body, then length sum
                  len_sum    = 33'(HDR_LEN) + {1'b0, body_in} + {1'b0, attr_in};
                  hdr_status = fault_in;
                  if (hdr_status == ST_OK && body_in == 32'd0)
                     hdr_status = ST_EMPTY_BODY;
                  if (hdr_status == ST_OK && {1'b0, total_in} != len_sum)
                     hdr_status = ST_LENGTH_MISMATCH;
                  if (hdr_status != ST_OK) begin
                     if (!emit) begin
                        emit        = 1'b1;
                        emit_status = hdr_status;
                     end
                     phase_in = PH_DISCARD;
                  end else begin
                     phase_in = PH_PAYLOAD;
                     if (req.end_of_store && !emit) begin
                        emit        = 1'b1;
                        emit_status = ST_TRUNCATED;
                     end
                  end
               end else if (req.end_of_store && !emit) begin
                  emit        = 1'b1;
                  emit_status = ST_TRUNCATED;
               end
            end
            PH_PAYLOAD: begin
               crc_run_in = crc_byte(crc_run_in, req.data_byte);
               count_in   = count_in + 32'd1;
               if (count_in == total_in) begin
                  emit        = 1'b1;
                  emit_status = (~crc_run_in == crc_stored_in) ? ST_OK : ST_CRC_MISMATCH;
                  phase_in    = PH_IDLE;
               end else if (req.end_of_store) begin
                  emit        = 1'b1;
                  emit_status = ST_TRUNCATED;
               end
            end
            default: ;
         endcase

         if (req.end_of_store)
            phase_in = PH_IDLE;
      end
   end

   // result register load
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_flags_in   = rsp_flags_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_body_in    = rsp_body_ff;
      rsp_attr_in    = rsp_attr_ff;
      rsp_logical_in = rsp_logical_ff;
      rsp_weight_in  = rsp_weight_ff;
      rsp_matched_in = rsp_matched_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         if (emit_old) begin
            rsp_flags_in   = flag_lo_ff[4:0];
            rsp_total_in   = total_ff;
            rsp_body_in    = body_ff;
            rsp_attr_in    = attr_ff;
            rsp_logical_in = logical_ff;
            rsp_weight_in  = $signed(weight_ff);
            rsp_matched_in = matched_ff;
         end else begin
            rsp_flags_in   = flag_lo_in[4:0];
            rsp_total_in   = total_in;
            rsp_body_in    = body_in;
            rsp_attr_in    = attr_in;
            rsp_logical_in = logical_in;
            rsp_weight_in  = $signed(weight_in);
            rsp_matched_in = matched_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         count_ff      <= 32'd0;
         fault_ff      <= ST_OK;
         flag_lo_ff    <= 8'd0;
         total_ff      <= 32'd0;
         body_ff       <= 32'd0;
         attr_ff       <= 32'd0;
         logical_ff    <= 32'd0;
         weight_ff     <= 32'd0;
         crc_stored_ff <= 32'd0;
         matched_ff    <= 64'd0;
         crc_run_ff    <= CRC_INIT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         fault_ff      <= fault_in;
         flag_lo_ff    <= flag_lo_in;
         total_ff      <= total_in;
         body_ff       <= body_in;
         attr_ff       <= attr_in;
         logical_ff    <= logical_in;
         weight_ff     <= weight_in;
         crc_stored_ff <= crc_stored_in;
         matched_ff    <= matched_in;
         crc_run_ff    <= crc_run_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload of the result word, no reset needed
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_flags_ff   <= rsp_flags_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_body_ff    <= rsp_body_in;
      rsp_attr_ff    <= rsp_attr_in;
      rsp_logical_ff <= rsp_logical_in;
      rsp_weight_ff  <= rsp_weight_in;
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.record_flags    = rsp_flags_ff;
   assign rsp.total_bytes     = rsp_total_ff;
   assign rsp.body_size       = rsp_body_ff;
   assign rsp.attribute_bytes = rsp_attr_ff;
   assign rsp.plain_body_size = rsp_logical_ff;
   assign rsp.proof_weight    = rsp_weight_ff;
   assign rsp.match_count     = rsp_matched_ff;

endmodule

`default_nettype wire

[bench/tb_crc_checked_record_validator_unit.sv]
// Self-checking bench for the record validator: record stream stimulus, predictor, scoreboard.
`timescale 1ns / 1ps

module tb_crc_checked_record_validator_unit;
   import crv_pkg::*;

   // one word of the input stream
   typedef struct {
      logic [7:0] data;
      bit         start;
      bit         eos;
   } stream_word_type;

   // one result word, as the block presents it
   typedef struct {
      status_type         status;
      logic [4:0]         flags;
      logic [31:0]        total_len;
      logic [31:0]        body_len;
      logic [31:0]        attr_len;
      logic [31:0]        logical_len;
      logic signed [31:0] weight;
      logic [63:0]        matched;
   } record_result_type;

   // header contents and payload size of one generated record
   typedef struct {
      logic [31:0] magic;
      logic [15:0] version;
      logic [15:0] flag_word;
      logic [31:0] total_len;
      logic [31:0] body_len;
      logic [31:0] attr_len;
      logic [31:0] logical_len;
      logic [31:0] weight;
      logic [31:0] crc_flip;   // xor onto the stored CRC; nonzero forces a CRC error
      logic [63:0] matched;
      int          payload_len;
   } record_plan_type;

   // Record walker kept in step with the block; every accepted input word goes through
   // note_word, which queues the result the block owes for it, if any.
   class scoreboard_type;
      phase_type          walk;
      logic [31:0]        seen;        // bytes of the open record taken so far
      status_type         fault;       // first header fault, ST_OK for none
      logic [15:0]        flag_word;
      logic [31:0]        total_len;
      logic [31:0]        body_len;
      logic [31:0]        attr_len;
      logic [31:0]        logical_len;
      logic signed [31:0] weight;
      logic [31:0]        stored_crc;
      logic [31:0]        crc_acc;
      logic [63:0]        matched;
      record_result_type  due[$];
      int                 failures;
      int                 results_checked;

      function new();
         walk = PH_IDLE;
         open_record();
         failures = 0;
         results_checked = 0;
      endfunction

      // reflected CRC-32, one byte, bit by bit
      static function logic [31:0] advance_crc(logic [31:0] crc, logic [7:0] b);
         logic [31:0] c;
         c = crc ^ {24'd0, b};
         repeat (8) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else      c = c >> 1;
         end
         return c;
      endfunction

      function void open_record();
         seen        = '0;
         fault       = ST_OK;
         flag_word   = '0;
         total_len   = '0;
         body_len    = '0;
         attr_len    = '0;
         logical_len = '0;
         weight      = '0;
         stored_crc  = '0;
         matched     = '0;
         crc_acc     = CRC_INIT;
      endfunction

      function void note_fault(status_type code);
         if (fault == ST_OK) fault = code;
      endfunction

      function void queue_result(status_type code);
         record_result_type r;
         r.status      = code;
         r.flags       = flag_word[4:0];
         r.total_len   = total_len;
         r.body_len    = body_len;
         r.attr_len    = attr_len;
         r.logical_len = logical_len;
         r.weight      = weight;
         r.matched     = matched;
         due.push_back(r);
      endfunction

      function void note_word(logic [7:0] b, bit start, bit eos);
         bit          owed;
         int unsigned off;
         int unsigned lane;
         status_type  verdict;
         logic [32:0] span;
         owed = 1'b0;
         // a start always opens a fresh record; an open one is cut short
         if (start) begin
            if (walk == PH_HEADER || walk == PH_PAYLOAD) begin
               queue_result(ST_TRUNCATED);
               owed = 1'b1;
            end
            open_record();
            walk = PH_HEADER;
         end
         if (walk == PH_HEADER) begin
            off  = seen;
            lane = (off % 4) * 8;
            if (off < 4) begin
               if (b != MAGIC_WORD[off*8 +: 8]) note_fault(ST_BAD_MAGIC);
            end else if (off == 4) begin
               if (b != REC_VERSION) note_fault(ST_BAD_VERSION);
            end else if (off == 5) begin
               if (b != 8'h00) note_fault(ST_BAD_VERSION);
            end else if (off == 6) begin
               flag_word[7:0] = b;
            end else if (off == 7) begin
               flag_word[15:8] = b;
               if ((flag_word & ~16'(FLAG_MASK)) != 16'h0000) note_fault(ST_RESERVED_FLAGS);
            end else if (off < 12) begin
               total_len[lane +: 8] = b;
            end else if (off < 16) begin
               body_len[lane +: 8] = b;
            end else if (off < 20) begin
               attr_len[lane +: 8] = b;
            end else if (off < 24) begin
               logical_len[lane +: 8] = b;
            end else if (off < 28) begin
               weight[lane +: 8] = b;
            end else if (off < 32) begin
               stored_crc[lane +: 8] = b;
            end else begin
               matched[(off - 32)*8 +: 8] = b;
            end
            seen++;
            if (seen == HDR_LEN) begin
               // header complete: faults, then empty body, then the 33-bit length sum
               verdict = fault;
               span = 33'(body_len) + 33'(attr_len) + 33'(HDR_LEN);
               if (verdict == ST_OK && body_len == '0) verdict = ST_EMPTY_BODY;
               if (verdict == ST_OK && 33'(total_len) != span) verdict = ST_LENGTH_MISMATCH;
               if (verdict != ST_OK) begin
                  if (!owed) queue_result(verdict);
                  walk = PH_DISCARD;
               end else begin
                  walk = PH_PAYLOAD;
                  if (eos && !owed) queue_result(ST_TRUNCATED);
               end
            end else if (eos && !owed) begin
               queue_result(ST_TRUNCATED);
            end
         end else if (walk == PH_PAYLOAD) begin
            crc_acc = advance_crc(crc_acc, b);
            seen++;
            if (seen == total_len) begin
               queue_result((~crc_acc == stored_crc) ? ST_OK : ST_CRC_MISMATCH);
               walk = PH_IDLE;
            end else if (eos) begin
               queue_result(ST_TRUNCATED);
            end
         end
         if (eos) walk = PH_IDLE;
      endfunction

      task report(string msg);
         if (failures < 40) $display("check failed at %0t: %s", $realtime, msg);
         failures++;
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
      endtask

      task check_result(record_result_type got);
         record_result_type want;
         results_checked++;
         if (due.size() == 0) begin
            report($sformatf("result with nothing owed, status %0d", got.status));
            return;
         end
         want = due.pop_front();
         compare_field("status", 64'(got.status), 64'(want.status));
         compare_field("record_flags", 64'(got.flags), 64'(want.flags));
         compare_field("total_bytes", 64'(got.total_len), 64'(want.total_len));
         compare_field("body_size", 64'(got.body_len), 64'(want.body_len));
         compare_field("attribute_bytes", 64'(got.attr_len), 64'(want.attr_len));
         compare_field("plain_body_size", 64'(got.logical_len), 64'(want.logical_len));
         compare_field("proof_weight", 64'(got.weight), 64'(want.weight));
         compare_field("match_count", got.matched, want.matched);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   crv_req_if req_bus ();
   crv_rsp_if rsp_bus ();

   crc_checked_record_validator_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   scoreboard_type   book = new();
   stream_word_type  stimulus[$];
   bit               calm = 1'b0;   // both sides run without gaps while set

   // mostly back to back, sometimes a short gap, rarely a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   // sound record with random header contents; total matches the sizes
   function automatic record_plan_type sound_plan(int unsigned body_n, int unsigned attr_n);
      record_plan_type p;
      p.magic       = MAGIC_WORD;
      p.version     = {8'h00, REC_VERSION};
      p.flag_word   = {11'd0, 5'($urandom_range(0, 31))};
      p.body_len    = body_n;
      p.attr_len    = attr_n;
      p.total_len   = 32'(HDR_LEN + body_n + attr_n);
      p.logical_len = $urandom;
      p.weight      = $urandom;
      p.matched     = {$urandom, $urandom};
      p.crc_flip    = '0;
      p.payload_len = body_n + attr_n;
      return p;
   endfunction

   // Lays the record out as words. cut > 0 keeps only the first cut bytes; end_here puts
   // end_of_store on the last word laid out.
   function automatic void queue_record(record_plan_type p, int cut, bit end_here);
      logic [7:0]      payload[$];
      logic [319:0]    head;
      logic [31:0]     crc;
      logic [7:0]      b;
      stream_word_type w;
      int              full;
      int              n;
      crc = CRC_INIT;
      for (int i = 0; i < p.payload_len; i++) begin
         b = 8'($urandom);
         payload.push_back(b);
         crc = scoreboard_type::advance_crc(crc, b);
      end
      head = {p.matched, ~crc ^ p.crc_flip, p.weight, p.logical_len, p.attr_len,
              p.body_len, p.total_len, p.flag_word, p.version, p.magic};
      full = HDR_LEN + p.payload_len;
      n = (cut > 0 && cut < full) ? cut : full;
      for (int i = 0; i < n; i++) begin
         w.data  = (i < HDR_LEN) ? head[i*8 +: 8] : payload[i - HDR_LEN];
         w.start = (i == 0);
         w.eos   = end_here && (i == n - 1);
         stimulus.push_back(w);
      end
   endfunction

   // bytes with no record start; ignored unless a record is open
   function automatic void queue_noise(int n);
      stream_word_type w;
      for (int i = 0; i < n; i++) begin
         w.data  = 8'($urandom);
         w.start = 1'b0;
         w.eos   = ($urandom_range(0, 7) == 0);
         stimulus.push_back(w);
      end
   endfunction

   initial begin : stimulus_driver
      record_plan_type p;
      stream_word_type w;
      int              cut;
      int              kind;
      int              lane;
      int              gap;
      int              random_words;
      int              random_records;
      int              words_before;
      bit              end_here;
      int unsigned     body_n;
      int unsigned     attr_n;

      req_bus.valid        = 1'b0;
      req_bus.data_byte    = 8'h00;
      req_bus.record_start = 1'b0;
      req_bus.end_of_store = 1'b0;

      // ---- directed records ----
      // field extremes on sound records
      p = sound_plan(1, 0);
      p.flag_word = 16'h0000; p.weight = 32'h8000_0000; p.logical_len = '0; p.matched = '0;
      queue_record(p, 0, 0);
      p = sound_plan(3, 2);
      p.flag_word = 16'h001f; p.weight = 32'h7fff_ffff; p.logical_len = '1; p.matched = '1;
      queue_record(p, 0, 0);
      // stored CRC off in both end bits
      p = sound_plan(4, 1);
      p.crc_flip = 32'h8000_0001;
      queue_record(p, 0, 0);
      // bad magic together with bad version: magic wins
      p = sound_plan(2, 0);
      p.magic[15:8] = 8'h00; p.version = 16'h0000;
      queue_record(p, 0, 0);
      // version wrong in the low byte, then in the high byte
      p = sound_plan(2, 1);
      p.version = 16'h0000;
      queue_record(p, 0, 0);
      p = sound_plan(2, 1);
      p.version = 16'h0101;
      queue_record(p, 0, 0);
      // reserved flag bits in byte 6, with an empty body that must lose
      p = sound_plan(1, 0);
      p.flag_word = 16'h00e0; p.body_len = '0; p.total_len = 32'(HDR_LEN); p.payload_len = 0;
      queue_record(p, 0, 0);
      // reserved flag bit in byte 7
      p = sound_plan(1, 0);
      p.flag_word = 16'h8000;
      queue_record(p, 0, 0);
      // empty body beats a wrong total
      p = sound_plan(0, 3);
      p.total_len = 32'd99;
      queue_record(p, 0, 0);
      // total that would match only with a 32-bit wrap
      p = sound_plan(1, 0);
      p.body_len = 32'hffff_fff0; p.total_len = 32'h0000_0018; p.payload_len = 4;
      queue_record(p, 0, 0);
      // all length fields at their top value
      p = sound_plan(1, 0);
      p.total_len = '1; p.body_len = '1; p.attr_len = '1; p.payload_len = 2;
      queue_record(p, 0, 0);
      // stray bytes while idle
      queue_noise(3);
      // huge body passes the header, then the next start cuts it short
      p = sound_plan(1, 0);
      p.body_len = 32'hffff_ff00; p.total_len = 32'hffff_ff28; p.payload_len = 5;
      queue_record(p, 0, 0);
      // store ends on the last byte of a complete record
      p = sound_plan(6, 0);
      queue_record(p, 0, 1);
      // store ends inside the header
      p = sound_plan(2, 2);
      queue_record(p, 17, 1);
      // store ends on the last header byte, sound header and faulty header
      p = sound_plan(2, 2);
      queue_record(p, HDR_LEN, 1);
      p = sound_plan(2, 2);
      p.version = 16'h0002;
      queue_record(p, HDR_LEN, 1);
      // header cut by the next start, which also ends the store: the new one is dropped
      p = sound_plan(1, 1);
      queue_record(p, 10, 0);
      p = sound_plan(1, 1);
      queue_record(p, 1, 1);
      // start with end while idle: truncated with empty fields
      p = sound_plan(1, 1);
      queue_record(p, 1, 1);
      // payload cut by the next start
      p = sound_plan(5, 3);
      queue_record(p, 44, 0);
      p = sound_plan(8, 6);
      queue_record(p, 0, 0);

      // ---- random records: mostly well formed, the rest faulty or broken ----
      random_words   = 0;
      random_records = 0;
      while (random_words < 580 || random_records < 12) begin
         kind = $urandom_range(0, 99);
         if (kind >= 96) queue_noise($urandom_range(1, 5));
         words_before = stimulus.size();
         body_n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 120) : $urandom_range(1, 8);
         attr_n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60) : $urandom_range(0, 6);
         p = sound_plan(body_n, attr_n);
         cut = 0;
         end_here = ($urandom_range(0, 5) == 0);
         if (kind >= 55 && kind < 63) begin
            p.crc_flip = $urandom | 32'h1;
         end else if (kind >= 63 && kind < 67) begin
            lane = $urandom_range(0, 3);
            p.magic[lane*8 +: 8] = p.magic[lane*8 +: 8] ^ 8'($urandom_range(1, 255));
            if ($urandom_range(0, 1)) p.version = 16'h0100;
         end else if (kind >= 67 && kind < 70) begin
            if ($urandom_range(0, 1)) p.version = {8'h00, 8'($urandom_range(0, 255))};
            else p.version = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
            if (p.version == {8'h00, REC_VERSION}) p.version = 16'h0000;
         end else if (kind >= 70 && kind < 73) begin
            if ($urandom_range(0, 1)) p.flag_word[15:8] = 8'($urandom_range(1, 255));
            else p.flag_word[7:5] = 3'($urandom_range(1, 7));
         end else if (kind >= 73 && kind < 76) begin
            p.body_len = '0;
            p.total_len = 32'(HDR_LEN + attr_n);
            p.payload_len = attr_n;
         end else if (kind >= 76 && kind < 80) begin
            if ($urandom_range(0, 1)) p.total_len = p.total_len + $urandom_range(1, 8);
            else p.total_len = p.total_len - $urandom_range(1, 8);
         end else if (kind >= 80 && kind < 92) begin
            cut = $urandom_range(1, HDR_LEN + p.payload_len - 1);
         end else if (kind >= 92 && kind < 96) begin
            cut = 1;
            end_here = 1'b1;
         end
         queue_record(p, cut, end_here);
         random_records++;
         random_words += stimulus.size() - words_before;
      end

      // synchronous reset, released away from the sampling edge
      repeat (4) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // words change on the falling edge, the handshake is judged on the rising edge
      for (int idx = 0; idx < stimulus.size(); idx++) begin
         w = stimulus[idx];
         calm = ((idx / 256) % 5 == 3);
         gap = calm ? 0 : pick_gap();
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
         end
         @(negedge clock);
         req_bus.valid        = 1'b1;
         req_bus.data_byte    = w.data;
         req_bus.record_start = w.start;
         req_bus.end_of_store = w.eos;
         @(posedge clock);
         while (req_bus.ready !== 1'b1) @(posedge clock);
         book.note_word(w.data, w.start, w.eos);
      end
      @(negedge clock);
      req_bus.valid = 1'b0;
      calm = 1'b0;

      // drain, then a few more cycles for any stray result
      while (book.due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (book.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Result side: random stalls, plus one long hold-off once results flow so that the
   // result register fills and the input is held back.
   initial begin : result_sink
      record_result_type got;
      int                stall_left;
      int                hold_left;
      int                n;
      bit                held;
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      hold_left  = 0;
      held       = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (!held && book.results_checked >= 30) begin
            held = 1'b1;
            hold_left = 399;
            rsp_bus.ready = 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            n = calm ? 0 : pick_gap();
            stall_left = (n > 0) ? n - 1 : 0;
            rsp_bus.ready = (n == 0);
         end
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.status      = rsp_bus.status;
            got.flags       = rsp_bus.record_flags;
            got.total_len   = rsp_bus.total_bytes;
            got.body_len    = rsp_bus.body_size;
            got.attr_len    = rsp_bus.attribute_bytes;
            got.logical_len = rsp_bus.plain_body_size;
            got.weight      = rsp_bus.proof_weight;
            got.matched     = rsp_bus.match_count;
            book.check_result(got);
         end
      end
   end

   // run limit, far beyond the slowest sound run
   initial begin : run_limit
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
